// ===== design/scs_pkg.sv =====
// shared constants and types for the shape collision test unit
// no dependencies

package scs_pkg;

  localparam logic [1:0] KIND_RECT   = 2'd1;
  localparam logic [1:0] KIND_CIRCLE = 2'd2;

  localparam logic ACT_POINT = 1'b0;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd5;

  typedef struct packed {
    logic dist_test;
    logic box_hit;
  } scs_ctl_t;

endpackage

// ===== design/scs_query_if.sv =====
// query channel interface: valid/ready plus one collision query
// depends on nothing; width set by COORD_BITS

interface scs_query_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] entity_x;
  logic signed [COORD_BITS-1:0] entity_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic [1:0]                   other_kind;
  logic signed [COORD_BITS-1:0] other_offset_x;
  logic signed [COORD_BITS-1:0] other_offset_y;
  logic [COORD_BITS-2:0]        other_width;
  logic [COORD_BITS-2:0]        other_height;
  logic [COORD_BITS-2:0]        other_radius;

  modport source (
    output valid, action, entity_x, entity_y, query_x, query_y, other_kind,
           other_offset_x, other_offset_y, other_width, other_height, other_radius,
    input  ready
  );

  modport sink (
    input  valid, action, entity_x, entity_y, query_x, query_y, other_kind,
           other_offset_x, other_offset_y, other_width, other_height, other_radius,
    output ready
  );
endinterface

// ===== design/scs_result_if.sv =====
// result channel interface: valid/ready plus the collision flag
// depends on nothing

interface scs_result_if;
  logic valid;
  logic ready;
  logic colliding;

  modport source (output valid, colliding, input ready);
  modport sink   (input valid, colliding, output ready);
endinterface

// ===== design/scs_front.sv =====
// placement and difference stages: shape positions, box tests, clamp and deltas
// depends on scs_pkg

module scs_front #(
  parameter int COORD_BITS = 32,
  parameter int EXT_BITS   = COORD_BITS + 3
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         action_i,
  input  logic signed [COORD_BITS-1:0] entity_x_i,
  input  logic signed [COORD_BITS-1:0] entity_y_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic [1:0]                   other_kind_i,
  input  logic signed [COORD_BITS-1:0] other_offset_x_i,
  input  logic signed [COORD_BITS-1:0] other_offset_y_i,
  input  logic [COORD_BITS-2:0]        other_width_i,
  input  logic [COORD_BITS-2:0]        other_height_i,
  input  logic [COORD_BITS-2:0]        other_radius_i,
  input  logic [1:0]                   own_kind_i,
  input  logic signed [COORD_BITS-1:0] own_offset_x_i,
  input  logic signed [COORD_BITS-1:0] own_offset_y_i,
  input  logic [COORD_BITS-2:0]        own_width_i,
  input  logic [COORD_BITS-2:0]        own_height_i,
  input  logic [COORD_BITS-2:0]        own_radius_i,
  output logic signed [EXT_BITS-1:0]   dx_o,
  output logic signed [EXT_BITS-1:0]   dy_o,
  output logic [COORD_BITS-1:0]        r_o,
  output scs_pkg::scs_ctl_t            ctl_o
);
  import scs_pkg::*;

  localparam int SX = EXT_BITS - COORD_BITS;
  localparam int SZ = EXT_BITS - COORD_BITS + 1;

  // stage 1: positions
  logic                       act_r;
  logic [1:0]                 okind_r;
  logic signed [EXT_BITS-1:0] sx_r, sy_r, qx_r, qy_r, ox_r, oy_r;
  logic [COORD_BITS-2:0]      ow_r, oh_r, orad_r;

  logic signed [EXT_BITS-1:0] ex_e, ey_e, qx_e, qy_e, offx_e, offy_e, oofx_e, oofy_e;

  assign ex_e   = {{SX{entity_x_i[COORD_BITS-1]}}, entity_x_i};
  assign ey_e   = {{SX{entity_y_i[COORD_BITS-1]}}, entity_y_i};
  assign qx_e   = {{SX{query_x_i[COORD_BITS-1]}}, query_x_i};
  assign qy_e   = {{SX{query_y_i[COORD_BITS-1]}}, query_y_i};
  assign offx_e = {{SX{own_offset_x_i[COORD_BITS-1]}}, own_offset_x_i};
  assign offy_e = {{SX{own_offset_y_i[COORD_BITS-1]}}, own_offset_y_i};
  assign oofx_e = {{SX{other_offset_x_i[COORD_BITS-1]}}, other_offset_x_i};
  assign oofy_e = {{SX{other_offset_y_i[COORD_BITS-1]}}, other_offset_y_i};

  always_ff @(posedge clk) begin
    if (en) begin
      act_r   <= action_i;
      okind_r <= other_kind_i;
      sx_r    <= ex_e + offx_e;
      sy_r    <= ey_e + offy_e;
      qx_r    <= qx_e;
      qy_r    <= qy_e;
      ox_r    <= qx_e + oofx_e;
      oy_r    <= qy_e + oofy_e;
      ow_r    <= other_width_i;
      oh_r    <= other_height_i;
      orad_r  <= other_radius_i;
    end
  end

  // stage 2: extents, box overlap, clamp, deltas
  logic signed [EXT_BITS-1:0] sxe, sye, oxe, oye;
  logic signed [EXT_BITS-1:0] mx, cx, my, cy, pmx, pcx, pmy, pcy;
  logic signed [EXT_BITS-1:0] dx_nxt, dy_nxt;
  logic [COORD_BITS-1:0]      r_nxt;
  scs_ctl_t                   ctl_nxt;

  assign sxe = sx_r + signed'({{SZ{1'b0}}, own_width_i});
  assign sye = sy_r + signed'({{SZ{1'b0}}, own_height_i});
  assign oxe = ox_r + signed'({{SZ{1'b0}}, ow_r});
  assign oye = oy_r + signed'({{SZ{1'b0}}, oh_r});

  // other circle centre clamped into own rectangle
  assign mx = (ox_r < sxe) ? ox_r : sxe;
  assign cx = (sx_r > mx) ? sx_r : mx;
  assign my = (oy_r < sye) ? oy_r : sye;
  assign cy = (sy_r > my) ? sy_r : my;
  // own circle centre clamped into other rectangle
  assign pmx = (sx_r < oxe) ? sx_r : oxe;
  assign pcx = (ox_r > pmx) ? ox_r : pmx;
  assign pmy = (sy_r < oye) ? sy_r : oye;
  assign pcy = (oy_r > pmy) ? oy_r : pmy;

  always_comb begin
    dx_nxt  = '0;
    dy_nxt  = '0;
    r_nxt   = '0;
    ctl_nxt = '0;
    priority if (act_r == ACT_POINT) begin
      priority if (own_kind_i == KIND_RECT) begin
        ctl_nxt.box_hit = (qx_r >= sx_r) && (qx_r <= sxe) && (qy_r >= sy_r) && (qy_r <= sye);
      end else if (own_kind_i == KIND_CIRCLE) begin
        ctl_nxt.dist_test = 1'b1;
        dx_nxt = qx_r - sx_r;
        dy_nxt = qy_r - sy_r;
        r_nxt  = {1'b0, own_radius_i};
      end else begin
        ctl_nxt = '0;
      end
    end else if (own_kind_i == KIND_RECT) begin
      priority if (okind_r == KIND_RECT) begin
        ctl_nxt.box_hit = (sx_r <= oxe) && (sxe >= ox_r) && (sy_r <= oye) && (sye >= oy_r);
      end else if (okind_r == KIND_CIRCLE) begin
        ctl_nxt.dist_test = 1'b1;
        dx_nxt = ox_r - cx;
        dy_nxt = oy_r - cy;
        r_nxt  = {1'b0, orad_r};
      end else begin
        ctl_nxt = '0;
      end
    end else if (own_kind_i == KIND_CIRCLE) begin
      priority if (okind_r == KIND_RECT) begin
        ctl_nxt.dist_test = 1'b1;
        dx_nxt = sx_r - pcx;
        dy_nxt = sy_r - pcy;
        r_nxt  = {1'b0, own_radius_i};
      end else if (okind_r == KIND_CIRCLE) begin
        ctl_nxt.dist_test = 1'b1;
        dx_nxt = ox_r - sx_r;
        dy_nxt = oy_r - sy_r;
        r_nxt  = {1'b0, own_radius_i} + {1'b0, orad_r};
      end else begin
        ctl_nxt = '0;
      end
    end else begin
      ctl_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_o  <= dx_nxt;
      dy_o  <= dy_nxt;
      r_o   <= r_nxt;
      ctl_o <= ctl_nxt;
    end
  end

endmodule

// ===== design/scs_dist.sv =====
// squared distance stage: registered squares, then sum and compare
// depends on scs_pkg

module scs_dist #(
  parameter int COORD_BITS = 32,
  parameter int EXT_BITS   = COORD_BITS + 3
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [EXT_BITS-1:0] dx_i,
  input  logic signed [EXT_BITS-1:0] dy_i,
  input  logic [COORD_BITS-1:0]      r_i,
  input  scs_pkg::scs_ctl_t          ctl_i,
  output logic                       hit_o
);
  import scs_pkg::*;

  localparam int MAG_BITS = EXT_BITS - 1;
  localparam int SQ_BITS  = 2 * MAG_BITS;
  localparam int SUM_BITS = SQ_BITS + 1;

  logic [EXT_BITS-1:0]     ax, ay;
  logic [MAG_BITS-1:0]     mx, my;
  logic [SQ_BITS-1:0]      sqx_r, sqy_r;
  logic [2*COORD_BITS-1:0] sqr_r;
  scs_ctl_t                ctl_r;
  logic [SUM_BITS-1:0]     sum;

  assign ax = dx_i[EXT_BITS-1] ? unsigned'(-dx_i) : unsigned'(dx_i);
  assign ay = dy_i[EXT_BITS-1] ? unsigned'(-dy_i) : unsigned'(dy_i);
  assign mx = ax[MAG_BITS-1:0];
  assign my = ay[MAG_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= mx * mx;
      sqy_r <= my * my;
      sqr_r <= r_i * r_i;
      ctl_r <= ctl_i;
    end
  end

  assign sum   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign hit_o = ctl_r.box_hit | (ctl_r.dist_test & (sum <= SUM_BITS'(sqr_r)));

endmodule

// ===== design/shape_collision_test_unit.sv =====
// shape collision test unit: owned rect/circle against a point or a second shape
// throughput 1 query per cycle while the pipeline advances
// the pipeline advances whenever the result register is empty or being taken
// synchronous active-low reset clears the pipeline valid bits and owned shape registers
// depends on scs_pkg, scs_query_if, scs_result_if, scs_front, scs_dist

module shape_collision_test_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  scs_query_if.sink                         in_q,
  scs_result_if.source                      out_res,
  input  logic                              cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [COORD_BITS-1:0]             cfg_data
);
  import scs_pkg::*;

  localparam int EXT_BITS = COORD_BITS + 3;

  logic [1:0]                   own_kind_r;
  logic signed [COORD_BITS-1:0] own_offset_x_r, own_offset_y_r;
  logic [COORD_BITS-2:0]        own_width_r, own_height_r, own_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_kind_r     <= '0;
      own_offset_x_r <= '0;
      own_offset_y_r <= '0;
      own_width_r    <= '0;
      own_height_r   <= '0;
      own_radius_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KIND:     own_kind_r     <= cfg_data[1:0];
        REG_OFFSET_X: own_offset_x_r <= cfg_data;
        REG_OFFSET_Y: own_offset_y_r <= cfg_data;
        REG_WIDTH:    own_width_r    <= cfg_data[COORD_BITS-2:0];
        REG_HEIGHT:   own_height_r   <= cfg_data[COORD_BITS-2:0];
        REG_RADIUS:   own_radius_r   <= cfg_data[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic v1_r, v2_r, v3_r, out_valid_r, colliding_r;

  assign adv        = !out_valid_r || out_res.ready;
  assign in_q.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_q.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  logic signed [EXT_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0]      r;
  scs_ctl_t                   ctl;
  logic                       hit;

  scs_front #(
    .COORD_BITS (COORD_BITS),
    .EXT_BITS   (EXT_BITS)
  ) u_front (
    .clk              (clk),
    .en               (adv),
    .action_i         (in_q.action),
    .entity_x_i       (in_q.entity_x),
    .entity_y_i       (in_q.entity_y),
    .query_x_i        (in_q.query_x),
    .query_y_i        (in_q.query_y),
    .other_kind_i     (in_q.other_kind),
    .other_offset_x_i (in_q.other_offset_x),
    .other_offset_y_i (in_q.other_offset_y),
    .other_width_i    (in_q.other_width),
    .other_height_i   (in_q.other_height),
    .other_radius_i   (in_q.other_radius),
    .own_kind_i       (own_kind_r),
    .own_offset_x_i   (own_offset_x_r),
    .own_offset_y_i   (own_offset_y_r),
    .own_width_i      (own_width_r),
    .own_height_i     (own_height_r),
    .own_radius_i     (own_radius_r),
    .dx_o             (dx),
    .dy_o             (dy),
    .r_o              (r),
    .ctl_o            (ctl)
  );

  scs_dist #(
    .COORD_BITS (COORD_BITS),
    .EXT_BITS   (EXT_BITS)
  ) u_dist (
    .clk   (clk),
    .en    (adv),
    .dx_i  (dx),
    .dy_i  (dy),
    .r_i   (r),
    .ctl_i (ctl),
    .hit_o (hit)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      colliding_r <= hit;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.colliding = colliding_r;

endmodule

// ===== design/scs_checker.sv =====
// port-level checks for the shape collision test unit, bound to the top level
// depends on shape_collision_test_unit

module scs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_colliding
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_colliding))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled output stalls the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule

bind shape_collision_test_unit scs_checker u_scs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_q.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_colliding (out_res.colliding)
);
